// ===== rtl/core/modified_utf8_to_utf16_decoder_core_macros.svh =====
// Assertion macros for the modified UTF-8 decoder core.
// Needs a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef MODIFIED_UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH
`define MODIFIED_UTF8_TO_UTF16_DECODER_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define MU8U16_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("decoder assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define MU8U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("decoder assertion failed: next-cycle check");

`else

`define MU8U16_ASSERT_NOW(label, ante, cons)
`define MU8U16_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/core/mu8u16_pkg.sv =====
// Shared types and constants for the modified UTF-8 to UTF-16 decoder.
// No dependencies; used by mu8u16_step and the core top level.
package mu8u16_pkg;

    // Count of bytes held from a sequence that is still open.
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_ONE  = 2'd1;
    localparam logic [1:0] HELD_TWO  = 2'd2;

    // Byte classes.
    localparam logic [7:0] ASCII_MAX    = 8'h7F;
    localparam logic [7:0] CONT_MASK    = 8'hC0;
    localparam logic [7:0] CONT_CODE    = 8'h80;
    localparam logic [7:0] LEAD2_MASK   = 8'hE0;
    localparam logic [7:0] LEAD2_CODE   = 8'hC0;
    localparam logic [7:0] LEAD3_MASK   = 8'hF0;
    localparam logic [7:0] LEAD3_CODE   = 8'hE0;

    // Decoder state carried from byte to byte.
    typedef struct packed {
        logic [1:0] held;
        logic [7:0] lead;
        logic [7:0] second;
        logic       discard;
    } dec_state_t;

    // One decode result.
    typedef struct packed {
        logic        valid;
        logic [15:0] unit;
        logic        bad;
        logic        done;
    } dec_result_t;

endpackage

// ===== rtl/core/mu8u16_step.sv =====
// Combinational decode of one byte against the held sequence state.
// Depends on mu8u16_pkg for the state and result structs and byte codes.
module mu8u16_step
    import mu8u16_pkg::*;
(
    input  dec_state_t  cur,
    input  logic [7:0]  data_byte,
    input  logic        end_of_string,
    output dec_state_t  nxt,
    output dec_result_t res
);

    logic        is_cont;
    logic        is_lead2;
    logic        is_lead3;
    logic        emit_unit;
    logic        emit_err;
    logic [15:0] unit_val;

    assign is_cont  = (data_byte & CONT_MASK) == CONT_CODE;
    assign is_lead2 = (data_byte & LEAD2_MASK) == LEAD2_CODE;
    assign is_lead3 = (data_byte & LEAD3_MASK) == LEAD3_CODE;

    // Classify the byte and pick the next sequence state.
    always_comb
    begin
        nxt       = cur;
        emit_unit = 1'b0;
        emit_err  = 1'b0;
        unit_val  = 16'd0;
        if (cur.discard)
        begin
            if (end_of_string)
            begin
                nxt.discard = 1'b0;
            end
        end
        else
        begin
            unique case (cur.held)
                HELD_ONE:
                begin
                    if (!is_cont)
                    begin
                        emit_err = 1'b1;
                    end
                    else if ((cur.lead & LEAD2_MASK) == LEAD2_CODE)
                    begin
                        emit_unit = 1'b1;
                        unit_val  = {5'd0, cur.lead[4:0], data_byte[5:0]};
                    end
                    else
                    begin
                        nxt.second = data_byte;
                        nxt.held   = HELD_TWO;
                        emit_err   = end_of_string;
                    end
                end
                HELD_TWO:
                begin
                    if (!is_cont)
                    begin
                        emit_err = 1'b1;
                    end
                    else
                    begin
                        emit_unit = 1'b1;
                        unit_val  = {cur.lead[3:0], cur.second[5:0], data_byte[5:0]};
                    end
                end
                default:
                begin
                    // Start of a sequence; the unused count of three lands here too.
                    nxt.held = HELD_NONE;
                    if (data_byte <= ASCII_MAX)
                    begin
                        emit_unit = 1'b1;
                        unit_val  = {8'd0, data_byte};
                    end
                    else if (is_lead2 || is_lead3)
                    begin
                        nxt.lead = data_byte;
                        nxt.held = HELD_ONE;
                        emit_err = end_of_string;
                    end
                    else
                    begin
                        emit_err = 1'b1;
                    end
                end
            endcase

            // Any result closes the open sequence.
            if (emit_unit || emit_err)
            begin
                nxt.held = HELD_NONE;
            end
            if (emit_err)
            begin
                nxt.discard = !end_of_string;
            end
        end
    end

    // Shape the result.
    always_comb
    begin
        res.valid = emit_unit || emit_err;
        res.unit  = emit_err ? 16'd0 : unit_val;
        res.bad   = emit_err;
        res.done  = emit_err || end_of_string;
    end

endmodule

// ===== rtl/core/modified_utf8_to_utf16_decoder_core.sv =====
// Top level of the modified UTF-8 to UTF-16 decoder: state and result registers.
// Depends on mu8u16_pkg, mu8u16_step and modified_utf8_to_utf16_decoder_core_macros.svh.
//
//  Channel  | Direction | tdata            | tuser        | tlast
//  s_axis   | in        | [7:0] data_byte  | -            | end_of_string
//  m_axis   | out       | [15:0] code_unit | bad_sequence | string_done
//
// One byte is taken per cycle unless the output stalls; its result, if any,
// appears in the result register in the cycle after the transfer. The decode of
// a byte is one pass of mask-and-shift logic from the held sequence state to the
// result register. Reset clears the sequence state and the result valid flag.
// A new byte is taken whenever the result register is empty or its result
// is being taken in the same cycle; a stalled output stops input transfers.
`include "modified_utf8_to_utf16_decoder_core_macros.svh"

module modified_utf8_to_utf16_decoder_core
    import mu8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] code_unit
    output logic        m_axis_tuser,   // [0] bad_sequence
    output logic        m_axis_tlast    // string_done
);

    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_res;
    logic        in_xfer;

    logic        out_valid_reg;
    logic [15:0] out_unit_reg;
    logic        out_bad_reg;
    logic        out_done_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // Decode of the incoming byte.
    mu8u16_step u_step (
        .cur           (state_reg),
        .data_byte     (s_axis_tdata),
        .end_of_string (s_axis_tlast),
        .nxt           (state_next),
        .res           (step_res)
    );

    // Sequence state advances on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_xfer)
        begin
            state_reg <= state_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= step_res.valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            out_unit_reg <= step_res.unit;
            out_bad_reg  <= step_res.bad;
            out_done_reg <= step_res.done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_unit_reg;
    assign m_axis_tuser  = out_bad_reg;
    assign m_axis_tlast  = out_done_reg;

    // An error result carries no code unit and closes the string.
    `MU8U16_ASSERT_NOW(a_err_closes, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 16'd0 && m_axis_tlast)
    // Bytes dropped after an error produce no result.
    `MU8U16_ASSERT_NEXT(a_discard_silent, in_xfer && state_reg.discard, !m_axis_tvalid)
    // While dropping bytes no sequence is held open.
    `MU8U16_ASSERT_NOW(a_discard_clear, state_reg.discard, state_reg.held == HELD_NONE)
    // The end mark always ends the dropping phase.
    `MU8U16_ASSERT_NEXT(a_eos_resync, in_xfer && s_axis_tlast, !state_reg.discard && state_reg.held == HELD_NONE)

endmodule
